### src/rgbgrad_pkg.sv
// Shared types, codes and helper functions for the RGB565 gradient pixel shader.
`default_nettype none

package rgbgrad_pkg;

    // Gradient mode codes as held in the mode register.
    localparam logic [2:0] MODE_SOLID  = 3'd0;
    localparam logic [2:0] MODE_HORIZ  = 3'd1;
    localparam logic [2:0] MODE_VERT   = 3'd2;
    localparam logic [2:0] MODE_DIAG   = 3'd3;
    localparam logic [2:0] MODE_LINEAR = 3'd4;
    localparam logic [2:0] MODE_RADIAL = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MODE         = 3'd0;
    localparam logic [2:0] CFG_START_COLOR  = 3'd1;
    localparam logic [2:0] CFG_END_COLOR    = 3'd2;
    localparam logic [2:0] CFG_LINEAR_ANGLE = 3'd3;
    localparam logic [2:0] CFG_CENTER_X     = 3'd4;
    localparam logic [2:0] CFG_CENTER_Y     = 3'd5;
    localparam logic [2:0] CFG_RADIUS       = 3'd6;

    localparam logic [8:0]  RATIO_FULL  = 9'd256;
    localparam logic [7:0]  COEF_DIAG   = 8'd181;
    localparam logic [15:0] RECIP_45    = 16'd46604;
    localparam int          RECIP_SHIFT = 21;
    localparam logic [5:0]  ANGLE_STEP  = 6'd45;

    // What the final stage does with a pixel.
    typedef enum logic [2:0] {
        SEL_START,
        SEL_END,
        SEL_ZERO,
        SEL_FULL,
        SEL_DIV,
        SEL_ROOT
    } sel_t;

    // One direction coefficient of the linear mode.
    typedef enum logic [2:0] {
        COEF_ZERO,
        COEF_P256,
        COEF_N256,
        COEF_P181,
        COEF_N181
    } coef_t;

    typedef struct packed {
        coef_t c;
        coef_t s;
    } coef_pair_t;

    // Cosine and sine of one of the eight 45-degree directions.
    function automatic coef_pair_t dir_coefs(input logic [2:0] dir);
        coef_pair_t r;
        unique case (dir)
            3'd0: r = '{c: COEF_P256, s: COEF_ZERO};
            3'd1: r = '{c: COEF_P181, s: COEF_P181};
            3'd2: r = '{c: COEF_ZERO, s: COEF_P256};
            3'd3: r = '{c: COEF_N181, s: COEF_P181};
            3'd4: r = '{c: COEF_N256, s: COEF_ZERO};
            3'd5: r = '{c: COEF_N181, s: COEF_N181};
            3'd6: r = '{c: COEF_ZERO, s: COEF_N256};
            3'd7: r = '{c: COEF_P181, s: COEF_N181};
            default: r = '{c: COEF_P256, s: COEF_ZERO};
        endcase
        return r;
    endfunction

    // start + floor((end - start) * ratio / 256), kept to six bits.
    function automatic logic [5:0] blend_ch(input logic [5:0] a, input logic [5:0] b,
                                            input logic [8:0] ratio);
        logic signed [6:0]  d;
        logic signed [16:0] p;
        logic        [8:0]  s;
        logic        [8:0]  sum;
        d   = $signed({1'b0, b}) - $signed({1'b0, a});
        p   = d * $signed({1'b0, ratio});
        s   = p[16:8];
        sum = {3'b000, a} + s;
        return sum[5:0];
    endfunction

endpackage

`default_nettype wire

### src/rgb565_gradient_pixel_shader_core.sv
// Top level of the RGB565 gradient pixel shader: a fully pipelined fill-color unit.
//
//  channel | direction | payload
//  s_      | in        | tdata: pixel_x, pixel_y, area_width, area_height
//  m_      | out       | tdata: pixel_color
//  cfg_    | in        | index and data of one configuration register
//
// One word is taken every cycle while m_ is not stalled; a result passes through stages A
// and B, stage C, the pipelined square root, three root bits per stage, the restoring divider,
// two quotient bits per stage, and the output register. Reset is synchronous and active low;
// it clears the configuration and angle registers and all valid bits. A stall on m_ freezes
// the whole pipeline and drops s_tready in the same cycle.
`default_nettype none

module rgb565_gradient_pixel_shader_core
    import rgbgrad_pkg::*;
#(
    parameter int COORD_BITS = 11
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // pixel_x, pixel_y, area_width, area_height (lowest bits first)
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // pixel_color
    output logic [15:0]              m_tdata,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int DW = 2*CB + 2;           // divider and root input width
    localparam int RB = CB + 1;             // root width
    localparam int RW = RB + 3;             // root remainder width
    localparam int LW = CB + 10;            // signed linear projection width
    localparam int SQ_STEPS  = 3;
    localparam int SQ_STAGES = (RB + SQ_STEPS - 1) / SQ_STEPS;
    localparam int DV_STEPS  = 2;
    localparam int Q_BITS    = 8;
    localparam int DV_STAGES = (Q_BITS + DV_STEPS - 1) / DV_STEPS;
    localparam int NS = SQ_STAGES + DV_STAGES;

    typedef struct packed {
        sel_t            sel;
        logic [DW-1:0]   num;
        logic [DW-1:0]   den;
        logic [DW-1:0]   sv;
        logic [RW-1:0]   srem;
        logic [RB-1:0]   sroot;
        logic [Q_BITS-1:0] q;
    } pipe_t;

    // Configuration registers.
    logic [2:0]         mode_reg;
    logic [15:0]        start_color_reg;
    logic [15:0]        end_color_reg;
    logic [15:0]        linear_angle_reg;
    logic [CB-1:0]      center_x_reg;
    logic [CB-1:0]      center_y_reg;
    logic [15:0]        radius_reg;
    logic [9:0]         angle_q_reg;
    logic [2:0]         dir_reg;
    logic [30:0]        angle_prod;

    logic adv;
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_SOLID;
            start_color_reg  <= '0;
            end_color_reg    <= '0;
            linear_angle_reg <= '0;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            radius_reg       <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODE:         mode_reg         <= cfg_data[2:0];
                CFG_START_COLOR:  start_color_reg  <= cfg_data;
                CFG_END_COLOR:    end_color_reg    <= cfg_data;
                CFG_LINEAR_ANGLE: linear_angle_reg <= cfg_data;
                CFG_CENTER_X:     center_x_reg     <= cfg_data[CB-1:0];
                CFG_CENTER_Y:     center_y_reg     <= cfg_data[CB-1:0];
                CFG_RADIUS:       radius_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // The angle picks a direction only if it is a non-negative multiple of 45;
    // the quotient comes from a reciprocal multiply and is then checked exactly.
    assign angle_prod = linear_angle_reg[14:0] * RECIP_45;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_q_reg <= '0;
            dir_reg     <= '0;
        end else begin
            angle_q_reg <= angle_prod[30:RECIP_SHIFT];
            if (!linear_angle_reg[15] &&
                linear_angle_reg[14:0] == 15'(angle_q_reg * ANGLE_STEP)) begin
                dir_reg <= angle_q_reg[2:0];
            end else begin
                dir_reg <= 3'd0;
            end
        end
    end

    // Stage A: unpack, patch zero sizes, offsets from the radial center.
    logic [CB-1:0]        xa_reg, ya_reg, wa_reg, ha_reg;
    logic signed [CB:0]   dxa_reg, dya_reg;
    logic                 va_reg;
    logic [CB-1:0]        in_x, in_y, in_w, in_h;

    assign in_x = s_tdata[CB-1:0];
    assign in_y = s_tdata[2*CB-1:CB];
    assign in_w = s_tdata[3*CB-1:2*CB];
    assign in_h = s_tdata[4*CB-1:3*CB];

    always_ff @(posedge aclk) begin
        if (adv) begin
            xa_reg  <= in_x;
            ya_reg  <= in_y;
            wa_reg  <= (in_w == '0) ? CB'(1) : in_w;
            ha_reg  <= (in_h == '0) ? CB'(1) : in_h;
            dxa_reg <= $signed({1'b0, in_x}) - $signed({1'b0, center_x_reg});
            dya_reg <= $signed({1'b0, in_y}) - $signed({1'b0, center_y_reg});
        end
    end

    // Stage B: products.
    logic [CB-1:0]          xb_reg, yb_reg, wb_reg, hb_reg;
    logic [2*CB-1:0]        xh_reg, yw_reg, wh_reg, dx2_reg, dy2_reg;
    logic [CB+7:0]          x181_reg, y181_reg, w181_reg, h181_reg;
    logic [31:0]            rsq_reg;
    logic                   vb_reg;
    logic signed [2*CB+1:0] dx2_full, dy2_full;

    assign dx2_full = dxa_reg * dxa_reg;
    assign dy2_full = dya_reg * dya_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            xb_reg   <= xa_reg;
            yb_reg   <= ya_reg;
            wb_reg   <= wa_reg;
            hb_reg   <= ha_reg;
            xh_reg   <= xa_reg * ha_reg;
            yw_reg   <= ya_reg * wa_reg;
            wh_reg   <= wa_reg * ha_reg;
            dx2_reg  <= dx2_full[2*CB-1:0];
            dy2_reg  <= dy2_full[2*CB-1:0];
            x181_reg <= xa_reg * COEF_DIAG;
            y181_reg <= ya_reg * COEF_DIAG;
            w181_reg <= wa_reg * COEF_DIAG;
            h181_reg <= ha_reg * COEF_DIAG;
            rsq_reg  <= radius_reg * radius_reg;
        end
    end

    function automatic logic signed [LW-1:0] pick(input coef_t c, input logic [CB-1:0] v,
                                                  input logic [CB+7:0] v181);
        logic signed [LW-1:0] m256;
        logic signed [LW-1:0] m181;
        logic signed [LW-1:0] r;
        m256 = $signed(LW'({v, 8'h00}));
        m181 = $signed(LW'(v181));
        unique case (c)
            COEF_ZERO: r = '0;
            COEF_P256: r = m256;
            COEF_N256: r = -m256;
            COEF_P181: r = m181;
            COEF_N181: r = -m181;
            default:   r = '0;
        endcase
        return r;
    endfunction

    // Stage C: sums and the decision of what each pixel needs.
    pipe_t               p_reg  [NS+1];
    pipe_t               p_next [NS];
    logic [NS:0]         v_reg;
    pipe_t               c_next;
    coef_pair_t          cs;
    logic [2*CB:0]       diag_num, dsq;
    logic signed [LW-1:0] dot, maxd;
    logic [DW-1:0]       lin_den;

    always_comb begin
        cs       = dir_coefs(dir_reg);
        diag_num = {1'b0, xh_reg} + {1'b0, yw_reg};
        dsq      = {1'b0, dx2_reg} + {1'b0, dy2_reg};
        dot      = pick(cs.c, xb_reg, x181_reg) + pick(cs.s, yb_reg, y181_reg);
        maxd     = pick(cs.c, wb_reg, w181_reg) + pick(cs.s, hb_reg, h181_reg);
        lin_den  = (maxd <= 0) ? DW'(1) : DW'(maxd[LW-2:0]);

        c_next       = '0;
        c_next.sel   = SEL_START;
        c_next.sv    = DW'(dsq);
        c_next.num   = DW'(dsq);
        c_next.den   = DW'(1);
        unique case (mode_reg)
            MODE_HORIZ: begin
                c_next.num = DW'(xb_reg);
                c_next.den = DW'(wb_reg);
                c_next.sel = (xb_reg >= wb_reg) ? SEL_FULL : SEL_DIV;
            end
            MODE_VERT: begin
                c_next.num = DW'(yb_reg);
                c_next.den = DW'(hb_reg);
                c_next.sel = (yb_reg >= hb_reg) ? SEL_FULL : SEL_DIV;
            end
            MODE_DIAG: begin
                c_next.num = DW'(diag_num);
                c_next.den = DW'({wh_reg, 1'b0});
                c_next.sel = ({1'b0, diag_num} >= {wh_reg, 1'b0}) ? SEL_FULL : SEL_DIV;
            end
            MODE_LINEAR: begin
                c_next.num = DW'(dot[LW-2:0]);
                c_next.den = lin_den;
                if (dot <= 0) begin
                    c_next.sel = SEL_ZERO;
                end else if (DW'(dot[LW-2:0]) >= lin_den) begin
                    c_next.sel = SEL_FULL;
                end else begin
                    c_next.sel = SEL_DIV;
                end
            end
            MODE_RADIAL: begin
                if (radius_reg == '0) begin
                    c_next.sel = SEL_START;
                end else if (32'(dsq) >= rsq_reg) begin
                    c_next.sel = SEL_END;
                end else begin
                    c_next.sel = SEL_ROOT;
                end
            end
            default: c_next.sel = SEL_START;
        endcase
    end

    // One bit of the digit-by-digit integer square root.
    function automatic pipe_t sqrt_step(input pipe_t t);
        pipe_t         r;
        logic [RW-1:0] rem_n;
        logic [RW-1:0] trial;
        r     = t;
        rem_n = {t.srem[RW-3:0], t.sv[DW-1:DW-2]};
        trial = RW'({t.sroot, 2'b01});
        if (rem_n >= trial) begin
            r.srem  = rem_n - trial;
            r.sroot = {t.sroot[RB-2:0], 1'b1};
        end else begin
            r.srem  = rem_n;
            r.sroot = {t.sroot[RB-2:0], 1'b0};
        end
        r.sv = {t.sv[DW-3:0], 2'b00};
        return r;
    endfunction

    // A radial pixel divides its root by the radius.
    function automatic pipe_t div_prep(input pipe_t t, input logic [15:0] rad);
        pipe_t r;
        r   = t;
        r.q = '0;
        if (t.sel == SEL_ROOT) begin
            r.sel = SEL_DIV;
            r.num = DW'(t.sroot);
            r.den = DW'(rad);
        end
        return r;
    endfunction

    // One quotient bit; num holds the running remainder.
    function automatic pipe_t div_step(input pipe_t t);
        pipe_t       r;
        logic [DW:0] t2;
        logic        ge;
        r  = t;
        t2 = {t.num, 1'b0};
        ge = t2 >= {1'b0, t.den};
        r.num = ge ? DW'(t2 - {1'b0, t.den}) : DW'(t2);
        r.q   = {t.q[Q_BITS-2:0], ge};
        return r;
    endfunction

    for (genvar k = 0; k < NS; k++) begin : g_stage
        always_comb begin : c_stage
            pipe_t t;
            t = p_reg[k];
            if (k < SQ_STAGES) begin
                for (int j = 0; j < SQ_STEPS; j++) begin
                    if (k*SQ_STEPS + j < RB) t = sqrt_step(t);
                end
            end else begin
                if (k == SQ_STAGES) t = div_prep(t, radius_reg);
                for (int j = 0; j < DV_STEPS; j++) begin
                    if ((k - SQ_STAGES)*DV_STEPS + j < Q_BITS) t = div_step(t);
                end
            end
            p_next[k] = t;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg[0] <= c_next;
            for (int k = 0; k < NS; k++) p_reg[k+1] <= p_next[k];
        end
    end

    // Final stage: ratio, channel blend, output register.
    logic [8:0]  ratio;
    logic [5:0]  r_bl, g_bl, b_bl;
    logic [15:0] color_next;
    logic [15:0] m_tdata_reg;
    logic        m_tvalid_reg;

    always_comb begin
        unique case (p_reg[NS].sel)
            SEL_FULL: ratio = RATIO_FULL;
            SEL_DIV:  ratio = {1'b0, p_reg[NS].q};
            default:  ratio = '0;
        endcase
        r_bl = blend_ch({1'b0, start_color_reg[15:11]}, {1'b0, end_color_reg[15:11]}, ratio);
        g_bl = blend_ch(start_color_reg[10:5], end_color_reg[10:5], ratio);
        b_bl = blend_ch({1'b0, start_color_reg[4:0]}, {1'b0, end_color_reg[4:0]}, ratio);
        unique case (p_reg[NS].sel)
            SEL_START: color_next = start_color_reg;
            SEL_END:   color_next = end_color_reg;
            default:   color_next = {r_bl[4:0], g_bl, b_bl[4:0]};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) m_tdata_reg <= color_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            v_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            va_reg       <= s_tvalid;
            vb_reg       <= va_reg;
            v_reg        <= {v_reg[NS-1:0], vb_reg};
            m_tvalid_reg <= v_reg[NS];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // A pixel sent to the divider must give a quotient below 256.
    a_div_below_full: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[0] && p_reg[0].sel == SEL_DIV |-> p_reg[0].num < p_reg[0].den)
        else $error("divider entered with numerator not below denominator");

    // Inside the circle the root stays below the radius.
    a_root_in_circle: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[SQ_STAGES] && p_reg[SQ_STAGES].sel == SEL_ROOT
        |-> DW'(p_reg[SQ_STAGES].sroot) < DW'(radius_reg))
        else $error("radial root not below radius");

    // Every radial pixel has left the root path before the last stage.
    a_no_root_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[NS] |-> p_reg[NS].sel != SEL_ROOT)
        else $error("root selection reached the blend stage");

    // A stall holds every valid bit of the pipeline.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(v_reg) && $stable(vb_reg) && $stable(va_reg))
        else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire
